[rtl/core/tdq_pkg.sv]
`default_nettype none

package tdq_pkg;

    localparam int TIME_WIDTH     = 48;
    localparam int INTERVAL_WIDTH = 32;
    localparam int LEAD_WIDTH     = 16;
    localparam int SLOT_WIDTH     = 4;

    localparam logic [LEAD_WIDTH-1:0] LEAD_RESET = 16'd100;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_ADDED     = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_CANCELLED = 3'd2,
        KIND_NOT_FOUND = 3'd3,
        KIND_EXPIRED   = 3'd4,
        KIND_TICK_DONE = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_ARM,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_op                       operation;
        logic [TIME_WIDTH-1:0]     now_time;
        logic [TIME_WIDTH-1:0]     deadline;
        logic [INTERVAL_WIDTH-1:0] reload_interval;
        logic [SLOT_WIDTH-1:0]     slot_id;
    } t_in_word;

    typedef struct packed {
        t_kind                     kind;
        logic [SLOT_WIDTH-1:0]     timer_slot;
        logic                      earliest_changed;
        logic [TIME_WIDTH-1:0]     next_deadline;
        logic                      next_valid;
        logic [TIME_WIDTH-1:0]     arm_delay;
        logic                      last;
    } t_out_word;

    typedef struct packed {
        logic [TIME_WIDTH-1:0]     deadline;
        logic [INTERVAL_WIDTH-1:0] interval;
    } t_slot_entry;

endpackage

`default_nettype wire

[rtl/core/timer_deadline_queue.sv]
`default_nettype none

// Timer table of NUM_SLOTS slots, each a deadline and a reload interval, all
// in microseconds. An add or cancel word gives a single result; a tick word
// gives, for k expired slots, one expired result per pass and a closing tick
// done result. Each pass reads the slot memory one slot per cycle through its
// single read port and a shared compare unit keeps the running minimum.
// Results appear for exactly one cycle on o_result with o_res_valid high and
// cannot be stalled; the result marked last closes the word and busy is low
// again by then. min_arm_lead is written through i_cfg_we/i_cfg_wdata; the
// user must write it only while busy is low: the block does not enforce it.
module timer_deadline_queue #(
    parameter int NUM_SLOTS = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    output logic                           busy,
    input  tdq_pkg::t_in_word              i_cmd,
    output logic                           o_res_valid,
    output tdq_pkg::t_out_word             o_result,
    input  wire                            i_cfg_we,
    input  wire  [tdq_pkg::LEAD_WIDTH-1:0] i_cfg_wdata
);
    import tdq_pkg::*;

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(NUM_SLOTS);
    localparam logic [AW+SLOT_WIDTH-1:0] SLOT_LIMIT = (AW + SLOT_WIDTH)'(NUM_SLOTS);

    t_state                  r_state, n_state;
    logic [NUM_SLOTS-1:0]    r_busy;
    logic [NUM_SLOTS-1:0]    r_done;
    logic [LEAD_WIDTH-1:0]   r_lead;
    logic [CW-1:0]           r_idx;
    logic                    r_rd_vld;
    logic [AW-1:0]           r_rd_idx;
    t_in_word                r_in;
    logic                    r_res_valid;
    t_out_word               r_result;

    logic                    r_best_any;
    logic [TIME_WIDTH-1:0]   r_best_dl;
    logic                    r_free_any;
    logic [AW-1:0]           r_free_idx;
    logic                    r_pick_any;
    logic [AW-1:0]           r_pick_idx;
    t_slot_entry             r_pick;
    t_kind                   r_kind;
    logic [SLOT_WIDTH-1:0]   r_slot;
    logic                    r_changed;
    logic [TIME_WIDTH:0]     r_diff;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    t_slot_entry             mem_wdata;
    logic [AW-1:0]           mem_raddr;
    t_slot_entry             mem_rdata;

    logic                    accept;
    logic [AW+SLOT_WIDTH-1:0] sid_ext;
    logic                    sid_hit;
    logic                    add_earlier;
    logic [TIME_WIDTH:0]     reload_sum;
    logic [TIME_WIDTH-1:0]   reload_dl;
    logic [AW+SLOT_WIDTH-1:0] free_ext;
    logic [AW+SLOT_WIDTH-1:0] pick_ext;
    logic [TIME_WIDTH-1:0]   lead_ext;
    logic [TIME_WIDTH-1:0]   arm_val;

    tdq_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

    assign sid_ext     = {{AW{1'b0}}, i_cmd.slot_id};
    assign sid_hit     = (sid_ext < SLOT_LIMIT) && r_busy[sid_ext[AW-1:0]];
    assign add_earlier = !r_best_any || (r_in.deadline < r_best_dl);
    assign reload_sum  = {1'b0, r_pick.deadline} + (TIME_WIDTH + 1)'(r_pick.interval);
    assign reload_dl   = reload_sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}}
                                                : reload_sum[TIME_WIDTH-1:0];
    assign free_ext    = {{SLOT_WIDTH{1'b0}}, r_free_idx};
    assign pick_ext    = {{SLOT_WIDTH{1'b0}}, r_pick_idx};
    assign lead_ext    = TIME_WIDTH'(r_lead);
    assign arm_val     = (!r_diff[TIME_WIDTH] && (r_diff[TIME_WIDTH-1:0] >= lead_ext))
                         ? r_diff[TIME_WIDTH-1:0] : lead_ext;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_cmd.operation != OP_NONE)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if ((r_in.operation == OP_TICK) && r_pick_any) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_ARM;
                end
            end
            ST_ARM:  n_state = ST_OUT;
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // memory control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_free_idx;
        mem_wdata = '{deadline: r_in.deadline, interval: r_in.reload_interval};
        mem_raddr = r_idx[AW-1:0];
        if (r_state == ST_EVAL) begin
            if (r_in.operation == OP_ADD) begin
                mem_we = r_free_any;
            end else if (r_in.operation == OP_TICK) begin
                mem_we    = r_pick_any && (r_pick.interval != '0);
                mem_waddr = r_pick_idx;
                mem_wdata = '{deadline: reload_dl, interval: r_pick.interval};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_busy      <= '0;
            r_lead      <= LEAD_RESET;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= 1'b0;
            r_rd_vld    <= (r_state == ST_SCAN) && (r_idx != LAST_IDX);
            if (i_cfg_we) begin
                r_lead <= i_cfg_wdata;
            end
            if (r_state == ST_SCAN && r_idx != LAST_IDX) begin
                r_idx <= r_idx + 1'b1;
            end else if (r_state != ST_SCAN) begin
                r_idx <= '0;
            end
            if (accept && (i_cmd.operation == OP_CANCEL) && sid_hit) begin
                r_busy[sid_ext[AW-1:0]] <= 1'b0;
            end
            if (r_state == ST_EVAL) begin
                if (r_in.operation == OP_ADD && r_free_any) begin
                    r_busy[r_free_idx] <= 1'b1;
                end else if (r_in.operation == OP_TICK && r_pick_any) begin
                    r_res_valid <= 1'b1;
                    if (r_pick.interval == '0) begin
                        r_busy[r_pick_idx] <= 1'b0;
                    end
                end
            end
            if (r_state == ST_OUT) begin
                r_res_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx[AW-1:0];
        // shared compare unit, one slot a cycle
        if (r_rd_vld) begin
            if (r_busy[r_rd_idx] && (!r_best_any || mem_rdata.deadline < r_best_dl)) begin
                r_best_any <= 1'b1;
                r_best_dl  <= mem_rdata.deadline;
            end
            if (!r_busy[r_rd_idx] && !r_free_any) begin
                r_free_any <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
            if ((r_in.operation == OP_TICK) && r_busy[r_rd_idx] && !r_done[r_rd_idx]
                && (mem_rdata.deadline <= r_in.now_time)
                && (!r_pick_any || mem_rdata.deadline < r_pick.deadline)) begin
                r_pick_any <= 1'b1;
                r_pick_idx <= r_rd_idx;
                r_pick     <= mem_rdata;
            end
        end
        if (accept) begin
            r_in       <= i_cmd;
            r_best_any <= 1'b0;
            r_free_any <= 1'b0;
            r_pick_any <= 1'b0;
            r_done     <= '0;
            r_changed  <= 1'b0;
            r_kind     <= sid_hit ? KIND_CANCELLED : KIND_NOT_FOUND;
            r_slot     <= i_cmd.slot_id;
        end
        if (r_state == ST_EVAL) begin
            unique case (r_in.operation)
                OP_ADD: begin
                    if (r_free_any) begin
                        r_kind    <= KIND_ADDED;
                        r_slot    <= free_ext[SLOT_WIDTH-1:0];
                        r_changed <= add_earlier;
                        if (add_earlier) begin
                            r_best_any <= 1'b1;
                            r_best_dl  <= r_in.deadline;
                        end
                    end else begin
                        r_kind <= KIND_FULL;
                        r_slot <= '0;
                    end
                end
                OP_TICK: begin
                    if (r_pick_any) begin
                        r_result <= '{kind: KIND_EXPIRED,
                                      timer_slot: pick_ext[SLOT_WIDTH-1:0],
                                      earliest_changed: 1'b0, next_deadline: '0,
                                      next_valid: 1'b0, arm_delay: '0, last: 1'b0};
                        r_done[r_pick_idx] <= 1'b1;
                        r_best_any <= 1'b0;
                        r_free_any <= 1'b0;
                        r_pick_any <= 1'b0;
                    end else begin
                        r_kind <= KIND_TICK_DONE;
                        r_slot <= '0;
                    end
                end
                OP_CANCEL, OP_NONE: begin
                end
                default: begin
                end
            endcase
        end
        if (r_state == ST_ARM) begin
            r_diff <= {1'b0, r_best_dl} - {1'b0, r_in.now_time};
        end
        if (r_state == ST_OUT) begin
            r_result <= '{kind: r_kind, timer_slot: r_slot, earliest_changed: r_changed,
                          next_deadline: r_best_any ? r_best_dl : '0,
                          next_valid: r_best_any,
                          arm_delay: r_best_any ? arm_val : '0,
                          last: 1'b1};
        end
    end

    a_last_ends_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_result.last) |-> (r_state == ST_IDLE))
        else $error("closing word while still busy");

    a_expired_mid_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_result.last) |-> (r_state == ST_SCAN && r_in.operation == OP_TICK))
        else $error("expired word outside a tick pass");

    a_no_result_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_res_valid)
        else $error("result right after accept");

    a_changed_only_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_result.earliest_changed) |->
            (o_result.kind == KIND_ADDED && o_result.next_valid))
        else $error("earliest_changed on a non-add word");

endmodule

`default_nettype wire

[rtl/core/tdq_slot_mem.sv]
`default_nettype none

module tdq_slot_mem #(
    parameter int NUM_SLOTS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire  [$clog2(NUM_SLOTS)-1:0] i_waddr,
    input  tdq_pkg::t_slot_entry         i_wdata,
    input  wire  [$clog2(NUM_SLOTS)-1:0] i_raddr,
    output tdq_pkg::t_slot_entry         o_rdata
);
    import tdq_pkg::*;

    t_slot_entry r_mem [NUM_SLOTS];
    t_slot_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
